// File: hw/rtl/swa_pkg.sv
// Shared types, constants and codes for the segmented waveform averager.
// Depends on nothing; swa_front, swa_back and the top level import it.
package swa_pkg;

    // Sum store geometry. The depth is a power of two, so store addresses
    // wrap by dropping the upper bits.
    localparam int STORE_DEPTH  = 65536;
    localparam int ADDR_W       = $clog2(STORE_DEPTH);
    localparam int EXT_W        = ADDR_W + 17;
    localparam int SAMPLE_WIDTH = 16;
    localparam int SUM_W        = 32;

    localparam logic [ADDR_W-1:0] ADDR_LAST = ADDR_W'(STORE_DEPTH - 1);
    localparam logic [EXT_W-1:0]  IDX_LIMIT = EXT_W'(STORE_DEPTH);

    localparam logic [SUM_W-1:0] SUM_MAX = 32'h7FFF_FFFF;
    localparam logic [SUM_W-1:0] SUM_MIN = 32'h8000_0000;

    // Opcodes on the input port.
    localparam logic [1:0] OP_ACC   = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;

    // Item kinds after decode in the front end.
    localparam logic [1:0] K_ACC   = 2'd0;
    localparam logic [1:0] K_READ  = 2'd1;
    localparam logic [1:0] K_CLEAR = 2'd2;
    localparam logic [1:0] K_NOP   = 2'd3;

    // Configuration register indexes.
    localparam logic [1:0] CFG_RECORD_LENGTH = 2'd0;
    localparam logic [1:0] CFG_NUM_SEGMENTS  = 2'd1;
    localparam logic [1:0] CFG_NUM_WAVEFORMS = 2'd2;
    localparam int         CFG_DATA_W        = 16;

    localparam logic [12:0] LEN_RESET  = 13'd1024;
    localparam logic [12:0] LEN_MAX    = 13'd4096;
    localparam logic [4:0]  SEGS_RESET = 5'd1;
    localparam logic [4:0]  SEGS_MAX   = 5'd16;
    localparam logic [15:0] WFMS_RESET = 16'd1;

    // Effective (clamped) configuration.
    typedef struct packed {
        logic [12:0] len;
        logic [4:0]  segs;
        logic [15:0] wfms;
    } t_cfg;

    // Decoded item handed from front to back.
    typedef struct packed {
        logic [1:0]              kind;
        logic [SAMPLE_WIDTH-1:0] smp;
        logic [ADDR_W-1:0]       raddr;
    } t_item;

    // One result item.
    typedef struct packed {
        logic [SUM_W-1:0] sum_value;
        logic             record_done;
        logic [31:0]      records_count;
        logic [31:0]      passes_count;
        logic             saturated;
    } t_result;

endpackage

// File: hw/rtl/swa_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
module swa_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: hw/rtl/swa_front.sv
// Front end: accepts input items, decodes them and queues them (two deep).
// Depends on swa_pkg.
module swa_front import swa_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_push,
    output logic                    o_full,
    input  logic [1:0]              i_opcode,
    input  logic signed [15:0]      i_sample,
    input  logic [15:0]             i_read_index,
    input  logic                    i_busy,
    output logic                    o_valid,
    output t_item                   o_item,
    input  logic                    i_pop
);

    t_item            r_q [2];
    logic             r_wp, n_wp;
    logic             r_rp, n_rp;
    logic [1:0]       r_cnt, n_cnt;
    logic             accept;
    t_item            dec;
    logic [31:0]      raw32;
    logic [EXT_W-1:0] idx_ext;

    // Decode: an out-of-range read behaves like an unused opcode.
    always_comb begin
        raw32     = 32'($unsigned(i_sample));
        idx_ext   = EXT_W'(i_read_index);
        dec.smp   = raw32[SAMPLE_WIDTH-1:0];
        dec.raddr = idx_ext[ADDR_W-1:0];
        case (i_opcode)
            OP_ACC:   dec.kind = K_ACC;
            OP_READ:  dec.kind = (idx_ext < IDX_LIMIT) ? K_READ : K_NOP;
            OP_CLEAR: dec.kind = K_CLEAR;
            default:  dec.kind = K_NOP;
        endcase
    end

    assign o_full  = (r_cnt == 2'd2) || i_busy;
    assign accept  = i_push && !o_full;
    assign o_valid = (r_cnt != 2'd0);
    assign o_item  = r_q[r_rp];

    always_comb begin
        n_wp  = accept ? ~r_wp : r_wp;
        n_rp  = i_pop ? ~r_rp : r_rp;
        n_cnt = r_cnt + 2'(accept) - 2'(i_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_q[r_wp] <= dec;
        end
    end

endmodule

// File: hw/rtl/swa_back.sv
// Back end: runs items against the sum store, keeps the record and pass
// counters, walks the store to clear it, and queues results (two deep).
// Depends on swa_pkg and swa_ram.
module swa_back import swa_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_cfg    i_cfg,
    input  logic    i_valid,
    input  t_item   i_item,
    output logic    o_pop,
    output logic    o_busy,
    output logic    o_empty,
    output t_result o_result,
    input  logic    i_res_pop
);

    localparam logic [1:0] ST_SWEEP = 2'd0;
    localparam logic [1:0] ST_IDLE  = 2'd1;
    localparam logic [1:0] ST_DATA  = 2'd2;

    logic [1:0]              r_state, n_state;
    logic [ADDR_W-1:0]       r_sweep, n_sweep;
    logic [11:0]             r_pos, n_pos;
    logic [15:0]             r_wcnt, n_wcnt;
    logic [15:0]             r_seg, n_seg;
    logic [31:0]             r_rec, n_rec;
    logic [31:0]             r_pas, n_pas;
    logic [1:0]              r_kind;
    logic [SAMPLE_WIDTH-1:0] r_smp;
    logic [ADDR_W-1:0]       r_addr;

    t_result                 r_oq [2];
    logic                    r_owp, r_orp;
    logic [1:0]              r_ocnt;
    logic                    res_push;
    t_result                 res;
    logic                    out_full;
    logic                    dispatch;

    logic [16:0]             acc_sum17;
    logic [EXT_W-1:0]        acc_ext;
    logic [ADDR_W-1:0]       acc_addr;
    logic [ADDR_W-1:0]       raddr;
    logic                    we;
    logic [ADDR_W-1:0]       waddr;
    logic [SUM_W-1:0]        wdata;
    logic [SUM_W-1:0]        rdata;

    logic [32:0]             s33;
    logic                    sat;
    logic [SUM_W-1:0]        sum_new;
    logic [12:0]             pos_inc;
    logic                    rec_end;
    logic [15:0]             wc_inc;
    logic                    seg_adv;
    logic [16:0]             seg_end;
    logic [16:0]             seg_next;

    swa_ram #(
        .WIDTH (SUM_W),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    assign out_full = (r_ocnt == 2'd2);
    assign dispatch = (r_state == ST_IDLE) && i_valid && !out_full;
    assign o_pop    = dispatch;
    assign o_busy   = (r_state == ST_SWEEP);
    assign o_empty  = (r_ocnt == 2'd0);
    assign o_result = r_oq[r_orp];

    // Store address of the next sample, wrapped to the store depth.
    always_comb begin
        acc_sum17 = 17'(r_seg) + 17'(r_pos);
        acc_ext   = EXT_W'(acc_sum17);
        acc_addr  = acc_ext[ADDR_W-1:0];
        raddr     = (i_item.kind == K_READ) ? i_item.raddr : acc_addr;
    end

    // Saturating add and record/segment bookkeeping.
    always_comb begin
        s33     = {rdata[SUM_W-1], rdata} + 33'($signed(r_smp));
        sat     = (s33[32] != s33[31]);
        sum_new = sat ? (s33[32] ? SUM_MIN : SUM_MAX) : s33[31:0];
        pos_inc = {1'b0, r_pos} + 13'd1;
        rec_end = (pos_inc >= i_cfg.len);
        wc_inc  = r_wcnt + 16'd1;
        seg_adv = (wc_inc >= i_cfg.wfms);
        seg_end = 17'(i_cfg.len) * 17'(i_cfg.segs);
        seg_next = {1'b0, r_seg} + 17'(i_cfg.len);
    end

    always_comb begin
        n_state  = r_state;
        n_sweep  = r_sweep;
        n_pos    = r_pos;
        n_wcnt   = r_wcnt;
        n_seg    = r_seg;
        n_rec    = r_rec;
        n_pas    = r_pas;
        we       = 1'b0;
        waddr    = r_addr;
        wdata    = sum_new;
        res_push = 1'b0;
        res      = '{sum_value: '0, record_done: 1'b0, records_count: r_rec,
                     passes_count: r_pas, saturated: 1'b0};
        case (r_state)
            ST_SWEEP: begin
                we    = 1'b1;
                waddr = r_sweep;
                wdata = '0;
                if (r_sweep == ADDR_LAST) begin
                    n_state = ST_IDLE;
                end else begin
                    n_sweep = r_sweep + ADDR_W'(1);
                end
            end
            ST_IDLE: begin
                if (dispatch) begin
                    case (i_item.kind)
                        K_ACC, K_READ: begin
                            n_state = ST_DATA;
                        end
                        K_CLEAR: begin
                            n_pos    = '0;
                            n_wcnt   = '0;
                            n_seg    = '0;
                            n_rec    = '0;
                            n_pas    = '0;
                            n_sweep  = '0;
                            n_state  = ST_SWEEP;
                            res_push = 1'b1;
                            res.records_count = '0;
                            res.passes_count  = '0;
                        end
                        default: begin
                            res_push = 1'b1;
                        end
                    endcase
                end
            end
            ST_DATA: begin
                n_state  = ST_IDLE;
                res_push = 1'b1;
                if (r_kind == K_ACC) begin
                    we = 1'b1;
                    if (rec_end) begin
                        n_pos  = '0;
                        n_rec  = r_rec + 32'd1;
                        n_wcnt = wc_inc;
                        if (seg_adv) begin
                            n_wcnt = '0;
                            if (seg_next >= seg_end) begin
                                n_seg = '0;
                                n_pas = r_pas + 32'd1;
                            end else begin
                                n_seg = seg_next[15:0];
                            end
                        end
                    end else begin
                        n_pos = pos_inc[11:0];
                    end
                    res.sum_value     = sum_new;
                    res.record_done   = rec_end;
                    res.saturated     = sat;
                    res.records_count = n_rec;
                    res.passes_count  = n_pas;
                end else begin
                    res.sum_value = rdata;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_SWEEP;
            r_sweep <= '0;
            r_pos   <= '0;
            r_wcnt  <= '0;
            r_seg   <= '0;
            r_rec   <= '0;
            r_pas   <= '0;
            r_owp   <= 1'b0;
            r_orp   <= 1'b0;
            r_ocnt  <= 2'd0;
        end else begin
            r_state <= n_state;
            r_sweep <= n_sweep;
            r_pos   <= n_pos;
            r_wcnt  <= n_wcnt;
            r_seg   <= n_seg;
            r_rec   <= n_rec;
            r_pas   <= n_pas;
            r_owp   <= res_push ? ~r_owp : r_owp;
            r_orp   <= (i_res_pop && !o_empty) ? ~r_orp : r_orp;
            r_ocnt  <= r_ocnt + 2'(res_push) - 2'(i_res_pop && !o_empty);
        end
    end

    always_ff @(posedge i_clk) begin
        if (dispatch) begin
            r_kind <= i_item.kind;
            r_smp  <= i_item.smp;
            r_addr <= acc_addr;
        end
        if (res_push) begin
            r_oq[r_owp] <= res;
        end
    end

endmodule

// File: hw/rtl/segmented_waveform_averager.sv
// Top level of the segmented waveform averager: configuration registers,
// front end (decode and input queue) and back end (sum store and counters).
// Depends on swa_pkg, swa_front, swa_back (and swa_ram below it).
//
//  channel | handshake       | payload
//  --------+-----------------+-------------------------------------------------
//  input   | push / full     | i_opcode, i_sample, i_read_index
//  result  | empty / pop     | o_sum_value, o_record_done, o_records_count,
//          |                 | o_passes_count, o_saturated
//  config  | i_cfg_we        | i_cfg_index, i_cfg_data
//
// An accumulate or read is dispatched in ST_IDLE, which presents the address
// to the store's registered read port; ST_DATA then queues the result, after
// adding and writing back for an accumulate. An unused opcode or out-of-range
// read queues its result straight from ST_IDLE. A clear queues its result and
// then walks the store one entry a cycle; reset starts the same walk, and full
// stays high through it. Two-deep queues on both sides let input transfers
// continue while a result waits for pop.
module segmented_waveform_averager import swa_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // input channel
    input  logic                  push,
    output logic                  full,
    input  logic [1:0]            i_opcode,
    input  logic signed [15:0]    i_sample,
    input  logic [15:0]           i_read_index,
    // result channel
    output logic                  empty,
    input  logic                  pop,
    output logic signed [31:0]    o_sum_value,
    output logic                  o_record_done,
    output logic [31:0]           o_records_count,
    output logic [31:0]           o_passes_count,
    output logic                  o_saturated,
    // configuration
    input  logic                  i_cfg_we,
    input  logic [1:0]            i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    logic [12:0] r_len;
    logic [4:0]  r_segs;
    logic [15:0] r_wfms;
    t_cfg        cfg;

    logic        busy;
    logic        item_valid;
    t_item       item;
    logic        item_pop;
    t_result     res;

    // Hold raw register values; clamp them when used.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len  <= LEN_RESET;
            r_segs <= SEGS_RESET;
            r_wfms <= WFMS_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_RECORD_LENGTH: r_len  <= i_cfg_data[12:0];
                CFG_NUM_SEGMENTS:  r_segs <= i_cfg_data[4:0];
                CFG_NUM_WAVEFORMS: r_wfms <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Zero acts as one; lengths and segment counts above the maximum clip.
    always_comb begin
        cfg.len  = (r_len == '0) ? 13'd1 : ((r_len > LEN_MAX) ? LEN_MAX : r_len);
        cfg.segs = (r_segs == '0) ? 5'd1 : ((r_segs > SEGS_MAX) ? SEGS_MAX : r_segs);
        cfg.wfms = (r_wfms == '0) ? 16'd1 : r_wfms;
    end

    swa_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .o_full       (full),
        .i_opcode     (i_opcode),
        .i_sample     (i_sample),
        .i_read_index (i_read_index),
        .i_busy       (busy),
        .o_valid      (item_valid),
        .o_item       (item),
        .i_pop        (item_pop)
    );

    swa_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (cfg),
        .i_valid   (item_valid),
        .i_item    (item),
        .o_pop     (item_pop),
        .o_busy    (busy),
        .o_empty   (empty),
        .o_result  (res),
        .i_res_pop (pop)
    );

    assign o_sum_value     = $signed(res.sum_value);
    assign o_record_done   = res.record_done;
    assign o_records_count = res.records_count;
    assign o_passes_count  = res.passes_count;
    assign o_saturated     = res.saturated;

endmodule

// File: tb/sv/segmented_waveform_averager_tb.sv
// Self-checking testbench for segmented_waveform_averager: a directed table,
// then randomized phases under stalls.
// Depends on swa_pkg and the RTL top level; reads no files.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import swa_pkg::*;

    // Opcode 3 and register index 3 are unused by the block.
    localparam logic [1:0] OP_NOP    = 2'd3;
    localparam logic [1:0] CFG_SPARE = 2'd3;

    // The limit is set well above the slowest correct run: reset and up to two
    // clears each walk 64K entries, and about 1350 items pass with random gaps on
    // both sides.
    localparam int unsigned CYCLE_LIMIT  = 2_000_000;
    localparam int unsigned SETTLE_TICKS = 16;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  push;
    logic                  full;
    logic [1:0]            i_opcode;
    logic signed [15:0]    i_sample;
    logic [15:0]           i_read_index;
    logic                  empty;
    logic                  pop = 1'b0;
    logic signed [31:0]    o_sum_value;
    logic                  o_record_done;
    logic [31:0]           o_records_count;
    logic [31:0]           o_passes_count;
    logic                  o_saturated;
    logic                  i_cfg_we;
    logic [1:0]            i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    segmented_waveform_averager i_dut (
        .i_clk,
        .i_rst_n,
        .push,
        .full,
        .i_opcode,
        .i_sample,
        .i_read_index,
        .empty,
        .pop,
        .o_sum_value,
        .o_record_done,
        .o_records_count,
        .o_passes_count,
        .o_saturated,
        .i_cfg_we,
        .i_cfg_index,
        .i_cfg_data
    );

    always begin
        i_clk = 1'b0;
        #1;
        i_clk = 1'b1;
        #1;
    end

    // ------------------------------------------------------------------
    // Predictor: own copy of the sum store, the record/segment walk and the
    // three registers, advanced once per accepted input transfer.
    // ------------------------------------------------------------------
    logic [31:0] acc_store [STORE_DEPTH];
    logic [11:0] rec_pos;
    logic [15:0] wfm_cnt;
    logic [15:0] seg_base;
    logic [31:0] rec_total;
    logic [31:0] pass_total;
    logic [12:0] len_reg;
    logic [4:0]  segs_reg;
    logic [15:0] wfms_reg;

    t_result     awaited_results [$];
    int unsigned mismatches;
    int unsigned cycle_count;
    bit          gaps_on;
    bit          fixed_valid;
    t_result     fixed_result;
    int unsigned pop_hold;

    // Zero registers act as 1; oversized ones clamp to the maximum.
    function automatic int unsigned active_len();
        if (len_reg == '0) return 1;
        if (len_reg > LEN_MAX) return LEN_MAX;
        return len_reg;
    endfunction

    function automatic int unsigned active_segs();
        if (segs_reg == '0) return 1;
        if (segs_reg > SEGS_MAX) return SEGS_MAX;
        return segs_reg;
    endfunction

    function automatic void wipe_state();
        foreach (acc_store[i]) acc_store[i] = '0;
        rec_pos    = '0;
        wfm_cnt    = '0;
        seg_base   = '0;
        rec_total  = '0;
        pass_total = '0;
    endfunction

    function automatic t_result average_step(logic [1:0] op, logic [15:0] smp,
                                             logic [15:0] idx);
        t_result           r;
        int unsigned       len;
        int unsigned       span;
        logic [ADDR_W-1:0] addr;
        longint            total;
        r = '0;
        case (op)
            OP_ACC: begin
                len = active_len();
                // Base plus position wraps with the store depth.
                addr  = seg_base + 16'(rec_pos);
                total = longint'($signed(acc_store[addr])) + longint'($signed(smp));
                if (total > longint'($signed(SUM_MAX))) begin
                    total = longint'($signed(SUM_MAX));
                    r.saturated = 1'b1;
                end
                if (total < longint'($signed(SUM_MIN))) begin
                    total = longint'($signed(SUM_MIN));
                    r.saturated = 1'b1;
                end
                r.sum_value     = total[31:0];
                acc_store[addr] = total[31:0];
                // A position at or past the record end completes the record.
                if (32'(rec_pos) + 1 >= len) begin
                    r.record_done = 1'b1;
                    rec_pos   = '0;
                    rec_total = rec_total + 32'd1;
                    wfm_cnt   = wfm_cnt + 16'd1;
                    if (wfm_cnt >= ((wfms_reg == '0) ? 16'd1 : wfms_reg)) begin
                        span    = len * active_segs();
                        wfm_cnt = '0;
                        // A segment at or past the last one wraps to zero.
                        if (32'(seg_base) + len >= span) begin
                            seg_base   = '0;
                            pass_total = pass_total + 32'd1;
                        end else begin
                            seg_base = seg_base + 16'(len);
                        end
                    end
                end else begin
                    rec_pos = rec_pos + 12'd1;
                end
            end
            OP_READ: begin
                r.sum_value = acc_store[idx];
            end
            OP_CLEAR: begin
                wipe_state();
            end
            default: ;
        endcase
        r.records_count = rec_total;
        r.passes_count  = pass_total;
        return r;
    endfunction

    task automatic check_field(string what, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, what, want, got);
            mismatches++;
        end
    endtask

    // ------------------------------------------------------------------
    // Monitor: predict on every input transfer, check on every result
    // transfer against the oldest awaited result.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : monitor
        t_result want;
        t_result got;
        if (i_rst_n) begin
            if (push && !full) begin
                want = average_step(i_opcode, i_sample, i_read_index);
                if (fixed_valid) want = fixed_result;
                awaited_results.insert(awaited_results.size(), want);
            end
            if (pop && !empty) begin
                got.sum_value     = o_sum_value;
                got.record_done   = o_record_done;
                got.records_count = o_records_count;
                got.passes_count  = o_passes_count;
                got.saturated     = o_saturated;
                if (awaited_results.size() == 0) begin
                    $display("%0t: result %0h arrived with nothing awaited",
                             $time, got);
                    mismatches++;
                end else begin
                    want = awaited_results.pop_front();
                    check_field("sum_value", want.sum_value, got.sum_value);
                    check_field("record_done", 32'(want.record_done), 32'(got.record_done));
                    check_field("records_count", want.records_count, got.records_count);
                    check_field("passes_count", want.passes_count, got.passes_count);
                    check_field("saturated", 32'(want.saturated), 32'(got.saturated));
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d results awaited", $time,
                     awaited_results.size());
            $display("status: fail");
            $finish;
        end
    end

    // Mostly short gaps, now and then a long one.
    function automatic int unsigned gap_cycles();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(4, 40);
    endfunction

    // Result side: hold pop low for a random stretch, then raise it again.
    always @(negedge i_clk) begin
        if (pop_hold != 0) begin
            pop <= 1'b0;
            pop_hold--;
        end else begin
            pop <= 1'b1;
            if (gaps_on && $urandom_range(0, 3) == 0) pop_hold = gap_cycles();
        end
    end

    // Called at a falling edge; returns at the falling edge after the transfer.
    // Push stays high into the next item unless a gap is inserted.
    task automatic send_item(logic [1:0] op, logic [15:0] smp, logic [15:0] idx,
                             bit fixed = 1'b0, t_result res = '0);
        int unsigned n;
        n = gaps_on ? gap_cycles() : 0;
        if (n != 0) begin
            push <= 1'b0;
            repeat (n) @(negedge i_clk);
        end
        push         <= 1'b1;
        i_opcode     <= op;
        i_sample     <= smp;
        i_read_index <= idx;
        fixed_valid  = fixed;
        fixed_result = res;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // Drop push and hold until every awaited result has been popped.
    task automatic drain_results();
        push <= 1'b0;
        do @(negedge i_clk); while (awaited_results.size() != 0);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [15:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        case (idx)
            CFG_RECORD_LENGTH: len_reg  = data[12:0];
            CFG_NUM_SEGMENTS:  segs_reg = data[4:0];
            CFG_NUM_WAVEFORMS: wfms_reg = data;
            default: ;
        endcase
        @(negedge i_clk);
    endtask

    // Only called with nothing in flight. A clear keeps walking the store
    // after its result has gone out, so let it start and wait for full to drop.
    task automatic set_config(logic [15:0] len_d, logic [15:0] segs_d,
                              logic [15:0] wfms_d, bit poke_spare = 1'b0);
        repeat (4) @(negedge i_clk);
        while (full) @(negedge i_clk);
        write_reg(CFG_RECORD_LENGTH, len_d);
        write_reg(CFG_NUM_SEGMENTS, segs_d);
        write_reg(CFG_NUM_WAVEFORMS, wfms_d);
        if (poke_spare) write_reg(CFG_SPARE, 16'($urandom));
        i_cfg_we <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Directed table: item rows, register rows, and rows whose result is
    // typed in (sum only, every other field zero).
    // ------------------------------------------------------------------
    typedef struct {
        bit          cfg;
        logic [15:0] cfg_len;
        logic [15:0] cfg_segs;
        logic [15:0] cfg_wfms;
        logic [1:0]  op;
        logic [15:0] smp;
        logic [15:0] idx;
        bit          fixed;
        t_result     res;
    } t_row;

    t_row dir_rows [$];

    function automatic t_row item_row(logic [1:0] op, logic [15:0] smp, logic [15:0] idx);
        t_row row;
        row     = '{default: '0};
        row.op  = op;
        row.smp = smp;
        row.idx = idx;
        return row;
    endfunction

    function automatic t_row fixed_row(logic [1:0] op, logic [15:0] smp, logic [15:0] idx,
                                       logic [31:0] sum);
        t_row row;
        row               = item_row(op, smp, idx);
        row.fixed         = 1'b1;
        row.res.sum_value = sum;
        return row;
    endfunction

    function automatic t_row cfg_row(logic [15:0] len_d, logic [15:0] segs_d,
                                     logic [15:0] wfms_d);
        t_row row;
        row          = '{default: '0};
        row.cfg      = 1'b1;
        row.cfg_len  = len_d;
        row.cfg_segs = segs_d;
        row.cfg_wfms = wfms_d;
        return row;
    endfunction

    // Append one row at the end of the table.
    function automatic void add_row(t_row row);
        dir_rows.insert(dir_rows.size(), row);
    endfunction

    initial begin
        int unsigned    sel;
        int unsigned    clears_left;
        logic [15:0]    smp;
        logic [15:0]    idx;
        logic [12:0]    len_pick;
        logic [4:0]     segs_pick;
        logic [15:0]    wfms_pick;

        i_rst_n      = 1'b0;
        push         = 1'b0;
        i_opcode     = OP_NOP;
        i_sample     = '0;
        i_read_index = '0;
        i_cfg_we     = 1'b0;
        i_cfg_index  = CFG_RECORD_LENGTH;
        i_cfg_data   = '0;
        gaps_on      = 1'b1;
        fixed_valid  = 1'b0;
        fixed_result = '0;
        mismatches   = 0;
        cycle_count  = 0;
        pop_hold     = 0;
        len_reg      = LEN_RESET;
        segs_reg     = SEGS_RESET;
        wfms_reg     = WFMS_RESET;
        wipe_state();

        // Reset values: empty store, zero counters, record length 1024.
        add_row(fixed_row(OP_READ, 16'h0000, 16'h0000, 32'h0000_0000));
        add_row(fixed_row(OP_READ, 16'h0000, 16'hFFFF, 32'h0000_0000));
        add_row(fixed_row(OP_NOP, 16'hFFFF, 16'hFFFF, 32'h0000_0000));
        // Sample extremes into fresh entries.
        add_row(fixed_row(OP_ACC, 16'h7FFF, 16'h0000, 32'h0000_7FFF));
        add_row(fixed_row(OP_ACC, 16'h8000, 16'h0000, 32'hFFFF_8000));
        add_row(item_row(OP_ACC, 16'h0000, 16'h0000));
        add_row(item_row(OP_ACC, 16'hFFFF, 16'h0000));
        add_row(fixed_row(OP_READ, 16'h0000, 16'h0000, 32'h0000_7FFF));
        add_row(fixed_row(OP_READ, 16'h0000, 16'h0001, 32'hFFFF_8000));
        add_row(item_row(OP_READ, 16'h0000, 16'h0003));
        // Shrink the record below the current position: next sample completes it.
        add_row(cfg_row(16'd3, 16'd2, 16'd1));
        add_row(item_row(OP_ACC, 16'd100, 16'h0000));
        add_row(item_row(OP_ACC, 16'd5, 16'h0000));
        add_row(item_row(OP_ACC, 16'hFFF9, 16'h0000));
        // Drop to one segment while on the second: the next record wraps.
        add_row(cfg_row(16'd3, 16'd1, 16'd1));
        add_row(item_row(OP_ACC, 16'd9, 16'h0000));
        add_row(item_row(OP_READ, 16'h0000, 16'h0003));
        add_row(item_row(OP_READ, 16'h0000, 16'h0004));
        add_row(item_row(OP_READ, 16'h0000, 16'h0005));
        // Clear returns zeros and empties the store.
        add_row(fixed_row(OP_CLEAR, 16'h0000, 16'h0000, 32'h0000_0000));
        add_row(fixed_row(OP_READ, 16'h0000, 16'h0004, 32'h0000_0000));
        add_row(fixed_row(OP_NOP, 16'h0000, 16'h0000, 32'h0000_0000));

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[k]) begin
            if (dir_rows[k].cfg) begin
                drain_results();
                set_config(dir_rows[k].cfg_len, dir_rows[k].cfg_segs, dir_rows[k].cfg_wfms);
            end else begin
                send_item(dir_rows[k].op, dir_rows[k].smp, dir_rows[k].idx,
                          dir_rows[k].fixed, dir_rows[k].res);
            end
        end

        // Random phases: registers rewritten between phases with the state
        // kept, the first three at the extremes, two of them out of range.
        clears_left = 1;
        for (int p = 0; p < 9; p++) begin
            drain_results();
            gaps_on = (p % 4 != 3);
            case (p)
                0: set_config({3'($urandom), 13'h1FFF}, {11'($urandom), 5'd31}, 16'd0);
                1: set_config({3'($urandom), 13'd0}, {11'($urandom), 5'd0}, 16'hFFFF, 1'b1);
                2: set_config(16'd4096, 16'd16, 16'd1);
                default: begin
                    case ($urandom_range(0, 7))
                        0: len_pick = 13'd0;
                        1: len_pick = 13'd4096;
                        2: len_pick = 13'($urandom_range(4097, 8191));
                        3: len_pick = 13'($urandom_range(9, 300));
                        default: len_pick = 13'($urandom_range(1, 8));
                    endcase
                    case ($urandom_range(0, 5))
                        0: segs_pick = 5'd0;
                        1: segs_pick = 5'd16;
                        2: segs_pick = 5'($urandom_range(17, 31));
                        default: segs_pick = 5'($urandom_range(1, 15));
                    endcase
                    case ($urandom_range(0, 5))
                        0: wfms_pick = 16'd0;
                        1: wfms_pick = 16'hFFFF;
                        default: wfms_pick = 16'($urandom_range(1, 4));
                    endcase
                    set_config({3'($urandom), len_pick}, {11'($urandom), segs_pick},
                               wfms_pick, ($urandom_range(0, 3) == 0));
                end
            endcase

            repeat (148) begin
                // Now and then hold the input until the output side catches up.
                if ($urandom_range(0, 199) == 0) drain_results();
                sel = $urandom_range(0, 999);
                if (sel < 700) begin
                    case ($urandom_range(0, 9))
                        0: smp = 16'h7FFF;
                        1: smp = 16'h8000;
                        default: smp = 16'($urandom);
                    endcase
                    send_item(OP_ACC, smp, 16'($urandom));
                end else if (sel < 900) begin
                    // Mostly read around the live segment, sometimes anywhere.
                    case ($urandom_range(0, 4))
                        0: idx = 16'hFFFF;
                        1: idx = 16'($urandom);
                        default: idx = seg_base + 16'($urandom_range(0, active_len()));
                    endcase
                    send_item(OP_READ, 16'($urandom), idx);
                end else if (sel < 990 || clears_left == 0) begin
                    send_item(OP_NOP, 16'($urandom), 16'($urandom));
                end else begin
                    clears_left--;
                    send_item(OP_CLEAR, 16'($urandom), 16'($urandom));
                end
            end
        end

        drain_results();
        repeat (SETTLE_TICKS) @(negedge i_clk);
        if (mismatches == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

// File: segmented_waveform_averager.f
hw/rtl/swa_pkg.sv
hw/rtl/swa_ram.sv
hw/rtl/swa_front.sv
hw/rtl/swa_back.sv
hw/rtl/segmented_waveform_averager.sv
tb/sv/segmented_waveform_averager_tb.sv
